// File: sv/binom_pkg.sv
// Shared types and constants for the binomial coefficient block.
package binom_pkg;

	localparam int unsigned MAX_N   = 63;
	localparam int unsigned ROW_D   = 64;
	localparam int unsigned ROW_AW  = 6;
	localparam int unsigned CNT_W   = 6;
	localparam int unsigned WAYS_W  = 60;
	localparam int unsigned S_DW    = 16;
	localparam int unsigned M_DW    = 64;

	typedef logic [ROW_AW-1:0] row_addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [WAYS_W-1:0] ways_t;

	// Row store access from the sequencer
	typedef struct packed {
		logic      we;
		row_addr_t waddr;
		ways_t     wdata;
		row_addr_t raddr;
	} row_req_t;

endpackage

// File: sv/binomial_coefficient_dp.sv
// Binomial coefficient C(n,k) computed by Pascal's rule on a shared adder.
//
// Each request (n, k) first clears cells 0..k of the row store (CLEAR), then
// for rows j = 1..n sets up the read (ROW, LOAD) and updates cells min(j,k)
// down to 1 (STEP); once ROW sees that the rows are done, the result is read
// out and registered (FETCH) and the block returns to idle. For k = 0 no row
// is updated; for k > n the request goes straight to FETCH with invalid set
// and ways zero. The row store has one read and one write port with a
// registered read, and the one 60-bit adder is shared by all cells. The block takes no
// new request until the result is registered; a result waiting at the output
// does not block the next request, but holds that request's result until the
// waiting one is transferred.
module binomial_coefficient_dp
	import binom_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [S_DW-1:0] s_tdata,  // [5:0] total_count, [11:6] choose_count
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [M_DW-1:0] m_tdata,  // [59:0] ways
	output logic            m_tuser   // [0] invalid
);

	row_req_t req;
	ways_t    rdata;
	ways_t    ways;

	binom_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.total_count  (s_tdata[CNT_W-1:0]),
		.choose_count (s_tdata[2*CNT_W-1:CNT_W]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.ways         (ways),
		.invalid      (m_tuser),
		.req          (req),
		.rdata        (rdata)
	);

	binom_row_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign m_tdata = {{(M_DW-WAYS_W){1'b0}}, ways};

endmodule

// File: sv/binom_row_ram.sv
// Row store of Pascal's triangle: one write port, one registered read port.
module binom_row_ram
	import binom_pkg::*;
(
	input  logic     clk,
	input  row_req_t req,
	output ways_t    rdata
);

	ways_t mem [ROW_D];
	ways_t rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/binom_seq.sv
// Sequencer and shared adder that build one Pascal row per request.
module binom_seq
	import binom_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  cnt_t     total_count,
	input  cnt_t     choose_count,
	output logic     out_valid,
	input  logic     out_ready,
	output ways_t    ways,
	output logic     invalid,
	output row_req_t req,
	input  ways_t    rdata
);

	typedef enum logic [2:0] {
		IDLE, CLEAR, ROW, LOAD, STEP, FETCH
	} state_t;

	state_t            state_q;
	cnt_t              n_q;
	cnt_t              k_q;
	logic [CNT_W:0]    j_q;
	cnt_t              i_q;
	ways_t             hi_q;
	logic              inv_q;
	logic              out_valid_q;
	ways_t             ways_q;
	logic              invalid_q;

	cnt_t              top;
	logic              row_done;
	logic              req_bad;
	logic              out_free;

	// Highest cell updated in row j
	assign top      = (j_q < {1'b0, k_q}) ? j_q[CNT_W-1:0] : k_q;
	assign row_done = (j_q > {1'b0, n_q}) || (top == '0);
	assign req_bad  = (choose_count > total_count) ||
	                  ({26'd0, total_count} > MAX_N[31:0]);
	assign out_free = !out_valid_q || out_ready;

	// Row store addressing and the shared adder
	always_comb begin
		req.we    = 1'b0;
		req.waddr = i_q;
		req.wdata = hi_q + rdata;
		req.raddr = k_q;
		unique case (state_q)
			CLEAR: begin
				req.we    = 1'b1;
				req.wdata = (i_q == '0) ? ways_t'(1) : '0;
			end
			ROW:  req.raddr = top;
			LOAD: req.raddr = i_q - cnt_t'(1);
			STEP: begin
				req.we    = 1'b1;
				req.raddr = i_q - cnt_t'(2);
			end
			default: req.raddr = k_q;
		endcase
	end

	// Sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
			ways_q      <= '0;
			invalid_q   <= 1'b0;
			n_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			i_q         <= '0;
			inv_q       <= 1'b0;
		end else begin
			// Register a new result, or drop the old one once transferred
			if (state_q == FETCH && out_free) begin
				out_valid_q <= 1'b1;
				ways_q      <= inv_q ? '0 : rdata;
				invalid_q   <= inv_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						n_q     <= total_count;
						k_q     <= choose_count;
						i_q     <= '0;
						inv_q   <= req_bad;
						state_q <= req_bad ? FETCH : CLEAR;
					end
				end
				// Clear cells 0..k, cell 0 gets one
				CLEAR: begin
					if (i_q == k_q) begin
						j_q     <= (CNT_W+1)'(1);
						state_q <= ROW;
					end else begin
						i_q <= i_q + cnt_t'(1);
					end
				end
				ROW: begin
					i_q     <= top;
					state_q <= row_done ? FETCH : LOAD;
				end
				LOAD: begin
					state_q <= STEP;
				end
				// Add neighbor into cell i, walk right to left
				STEP: begin
					if (i_q == cnt_t'(1)) begin
						j_q     <= j_q + (CNT_W+1)'(1);
						state_q <= ROW;
					end else begin
						i_q <= i_q - cnt_t'(1);
					end
				end
				FETCH: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// Carried neighbor for the adder
	always_ff @(posedge clk) begin
		if (state_q == LOAD || state_q == STEP) begin
			hi_q <= rdata;
		end
	end

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;
	assign ways      = ways_q;
	assign invalid   = invalid_q;

endmodule

// File: sv/binom_checker.sv
// Port-level checks for the binomial coefficient block, bound to the top level.
module binom_checker
	import binom_pkg::*;
(
	input logic            clk,
	input logic            arst_n,
	input logic            s_tvalid,
	input logic            s_tready,
	input logic [S_DW-1:0] s_tdata,
	input logic            m_tvalid,
	input logic            m_tready,
	input logic [M_DW-1:0] m_tdata,
	input logic            m_tuser
);

	// Busy after every input transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted back to back");

	// Invalid result carries zero ways
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("invalid result with nonzero ways");

	// Valid result is at least one
	a_valid_nz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata != '0)
		else $error("valid result of zero ways");

	// Stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

endmodule

bind binomial_coefficient_dp binom_checker u_chk (.*);

// File: bench/tb_binomial_coefficient_dp.sv
// Self-checking testbench for binomial_coefficient_dp: directed table, random requests, stalls.
`timescale 1ns / 100ps

module tb_binomial_coefficient_dp;
	import binom_pkg::*;

	localparam int DIR_N    = 20;
	localparam int RAND_N   = 270;
	localparam int TOTAL_N  = DIR_N + RAND_N;
	localparam int HOLD_CYC = 4000;
	localparam int DRAIN_CYC = 2100;

	// One expected answer, tagged with the request that caused it
	typedef struct packed {
		cnt_t  n;
		cnt_t  k;
		ways_t ways;
		logic  invalid;
	} binom_res_t;

	// Directed request; typed rows carry their answer in the table
	typedef struct packed {
		cnt_t  n;
		cnt_t  k;
		logic  typed;
		ways_t ways;
		logic  invalid;
	} dir_row_t;

	logic            clk;
	logic            arst_n;
	logic            s_tvalid;
	logic            s_tready;
	logic [S_DW-1:0] s_tdata;   // [5:0] total_count, [11:6] choose_count
	logic            m_tvalid;
	logic            m_tready;
	logic [M_DW-1:0] m_tdata;   // [59:0] ways
	logic            m_tuser;   // [0] invalid

	binom_res_t  pending_ways [$];
	dir_row_t    dir_rows [0:DIR_N-1];
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	bit          hold_pending;
	int unsigned error_count;
	int unsigned results_seen;
	int unsigned invalid_seen;
	int unsigned input_stall_cycles;
	int unsigned largest_n;

	binomial_coefficient_dp dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs
	initial begin
		#20_000_000;
		$display("timeout: %0d results still pending", pending_ways.size());
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("MISMATCH result %0d: %s", results_seen, msg);
	endtask

	// Build row n of Pascal's triangle up to entry k and return C(n,k)
	function automatic binom_res_t predict_ways(input cnt_t n, input cnt_t k);
		logic [63:0] row [ROW_D];
		binom_res_t  res;
		int          top;
		res.n       = n;
		res.k       = k;
		res.ways    = '0;
		res.invalid = 1'b1;
		if (k > n || n > MAX_N)
			return res;
		for (int i = 0; i <= k; i++)
			row[i] = '0;
		row[0] = 64'd1;
		for (int j = 1; j <= n; j++) begin
			top = (j < k) ? j : k;
			for (int i = top; i >= 1; i--)
				row[i] = row[i] + row[i-1];
		end
		res.ways    = row[k][WAYS_W-1:0];
		res.invalid = 1'b0;
		return res;
	endfunction

	// Offer one request, hold it until the transfer, then queue its answer
	task automatic send_request(input cnt_t n, input cnt_t k, input binom_res_t answer);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_DW-2*CNT_W){1'b0}}, k, n};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_ways.push_back(answer);
		if (answer.invalid)
			invalid_seen++;
		if (n > largest_n)
			largest_n = 32'(n);
	endtask

	// Pick the idling mix for the third of the run that item idx falls in
	task automatic set_phase(input int idx);
		int ph;
		ph = idx * 3 / TOTAL_N;
		case (ph)
			0: begin
				send_idle_pct = 7;
				recv_idle_pct = 61;
			end
			1: begin
				send_idle_pct = 61;
				recv_idle_pct = 7;
			end
			default: begin
				if (send_idle_pct != 0 || recv_idle_pct != 0)
					hold_pending = 1'b1;
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	task automatic check_result(input logic [M_DW-1:0] data, input logic flag);
		binom_res_t want;
		results_seen++;
		if (pending_ways.size() == 0) begin
			report_mismatch($sformatf("unexpected result ways=%0d invalid=%b",
				data[WAYS_W-1:0], flag));
			return;
		end
		want = pending_ways.pop_front();
		if (data[WAYS_W-1:0] !== want.ways)
			report_mismatch($sformatf("C(%0d,%0d) ways got %0d want %0d",
				want.n, want.k, data[WAYS_W-1:0], want.ways));
		if (data[M_DW-1:WAYS_W] !== '0)
			report_mismatch($sformatf("C(%0d,%0d) tdata padding %h not zero",
				want.n, want.k, data[M_DW-1:WAYS_W]));
		if (flag !== want.invalid)
			report_mismatch($sformatf("C(%0d,%0d) invalid got %b want %b",
				want.n, want.k, flag, want.invalid));
	endtask

	// Result side: check each transfer, stall at random, one long hold-off
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_result(m_tdata, m_tuser);
			if (hold_pending) begin
				hold_pending = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYC) begin
					@(posedge clk);
					if (s_tvalid && !s_tready)
						input_stall_cycles++;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Request side: reset, directed table, then random requests
	initial begin
		binom_res_t answer;
		cnt_t       n;
		cnt_t       k;
		arst_n             = 1'b0;
		s_tvalid           = 1'b0;
		s_tdata            = '0;
		error_count        = 0;
		results_seen       = 0;
		invalid_seen       = 0;
		input_stall_cycles = 0;
		largest_n          = 0;
		hold_pending       = 1'b0;
		send_idle_pct      = 0;
		recv_idle_pct      = 0;
		dir_rows = '{
			'{6'd0,  6'd0,  1'b1, 60'd1,  1'b0},  // empty set from nothing
			'{6'd63, 6'd0,  1'b1, 60'd1,  1'b0},
			'{6'd63, 6'd63, 1'b1, 60'd1,  1'b0},
			'{6'd0,  6'd63, 1'b1, 60'd0,  1'b1},  // k above n
			'{6'd62, 6'd63, 1'b1, 60'd0,  1'b1},
			'{6'd0,  6'd1,  1'b1, 60'd0,  1'b1},
			'{6'd1,  6'd0,  1'b1, 60'd1,  1'b0},
			'{6'd1,  6'd1,  1'b1, 60'd1,  1'b0},
			'{6'd63, 6'd1,  1'b1, 60'd63, 1'b0},
			'{6'd63, 6'd62, 1'b1, 60'd63, 1'b0},
			'{6'd5,  6'd5,  1'b1, 60'd1,  1'b0},
			'{6'd32, 6'd33, 1'b1, 60'd0,  1'b1},
			'{6'd63, 6'd31, 1'b0, 60'd0,  1'b0},  // widest value
			'{6'd63, 6'd32, 1'b0, 60'd0,  1'b0},
			'{6'd62, 6'd31, 1'b0, 60'd0,  1'b0},
			'{6'd2,  6'd1,  1'b0, 60'd0,  1'b0},
			'{6'd10, 6'd3,  1'b0, 60'd0,  1'b0},
			'{6'd20, 6'd10, 1'b0, 60'd0,  1'b0},
			'{6'd40, 6'd20, 1'b0, 60'd0,  1'b0},
			'{6'd42, 6'd21, 1'b0, 60'd0,  1'b0}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int idx = 0; idx < TOTAL_N; idx++) begin
			set_phase(idx);
			if (idx < DIR_N) begin
				n = dir_rows[idx].n;
				k = dir_rows[idx].k;
				if (dir_rows[idx].typed) begin
					answer.n       = n;
					answer.k       = k;
					answer.ways    = dir_rows[idx].ways;
					answer.invalid = dir_rows[idx].invalid;
				end else begin
					answer = predict_ways(n, k);
				end
			end else begin
				// Mostly short rows so the run stays quick; some span the full range
				if ($urandom_range(0, 99) < 20)
					n = cnt_t'($urandom_range(0, 63));
				else
					n = cnt_t'($urandom_range(0, 24));
				if ($urandom_range(0, 99) < 85)
					k = cnt_t'($urandom_range(0, n));
				else
					k = cnt_t'($urandom_range(0, 63));
				answer = predict_ways(n, k);
			end
			send_request(n, k, answer);
		end
		s_tvalid <= 1'b0;

		// Drain, then give the block time to emit anything extra
		while (pending_ways.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Covered %0d requests (%0d invalid), n up to %0d, %0d results checked.",
			TOTAL_N, invalid_seen, largest_n, results_seen);
		$display("Input stalled %0d cycles during the output hold-off; %0d mismatches.",
			input_stall_cycles, error_count);
		if (error_count == 0 && pending_ways.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// File: binomial_coefficient_dp.f
sv/binom_pkg.sv
sv/binom_row_ram.sv
sv/binom_seq.sv
sv/binomial_coefficient_dp.sv
sv/binom_checker.sv
bench/tb_binomial_coefficient_dp.sv
